// ----- src/hbcs_pkg.sv -----
`timescale 1ns / 1ps
package hbcs_pkg;

  typedef logic [4:0][7:0] rows_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  localparam logic [7:0] ADDR_VENDOR_LO  = 8'h00;
  localparam logic [7:0] ADDR_VENDOR_HI  = 8'h01;
  localparam logic [7:0] ADDR_DEVICE_LO  = 8'h02;
  localparam logic [7:0] ADDR_DEVICE_HI  = 8'h03;
  localparam logic [7:0] ADDR_BASE_CLASS = 8'h0B;
  localparam logic [7:0] ADDR_CMD      = 8'h04;
  localparam logic [7:0] ADDR_STATUS   = 8'h07;
  localparam logic [7:0] ADDR_LAT      = 8'h0D;
  localparam logic [7:0] ADDR_BIST     = 8'h0F;
  localparam logic [7:0] ADDR_PCON     = 8'h50;
  localparam logic [7:0] ADDR_CC       = 8'h52;
  localparam logic [7:0] ADDR_DRAMC    = 8'h57;
  localparam logic [7:0] ADDR_DRAMT    = 8'h58;
  localparam logic [7:0] ADDR_PAM0     = 8'h59;
  localparam logic [7:0] ADDR_PAM1     = 8'h5A;
  localparam logic [7:0] ADDR_PAM6     = 8'h5F;
  localparam logic [7:0] ADDR_DRB0     = 8'h60;
  localparam logic [7:0] ADDR_DRB4     = 8'h64;
  localparam logic [7:0] ADDR_DRT      = 8'h68;
  localparam logic [7:0] ADDR_SMRAM    = 8'h72;

  localparam logic [7:0] SMRAM_RESET   = 8'h02;
  localparam logic [9:0] RAM_RESET_MB  = 10'd64;
  localparam logic [7:0] FUNC_ABSENT   = 8'hFF;
  localparam logic [2:0] FUNC_HOST     = 3'd0;

  localparam logic [1:0] ROUTE_EXT     = 2'd0;
  localparam logic [1:0] ROUTE_INT     = 2'd1;
  localparam logic [1:0] ROUTE_INT_RD  = 2'd2;

  localparam logic       OP_READ       = 1'b0;
  localparam logic       OP_WRITE      = 1'b1;

  localparam logic [3:0] PAM0_WINDOW   = 4'd12;

  function automatic logic [7:0] rst_byte(logic [7:0] a);
    logic [7:0] r;
    case (a)
      ADDR_VENDOR_LO:  r = 8'h86;
      ADDR_VENDOR_HI:  r = 8'h80;
      ADDR_DEVICE_LO:  r = 8'h2D;
      ADDR_DEVICE_HI:  r = 8'h12;
      ADDR_BASE_CLASS: r = 8'h06;
      ADDR_CC:         r = 8'hB2;
      ADDR_DRAMC:      r = 8'h03;
      ADDR_SMRAM:      r = SMRAM_RESET;
      default:         r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] floor_pow2(logic [6:0] v);
    logic [6:0] r;
    r = 7'd1;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) begin
        r    = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic rows_t derive_rows(logic [9:0] ram);
    logic [7:0] t;
    logic [6:0] s0;
    logic [6:0] s1;
    logic [7:0] rem;
    logic [7:0] acc;
    rows_t      r;
    if (ram < 10'd8) begin
      t = 8'd8;
    end else if (ram > 10'd128) begin
      t = 8'd128;
    end else begin
      t = ram[7:0];
    end
    s0  = floor_pow2((t < 8'd64) ? t[6:0] : 7'd64);
    rem = t - {1'b0, s0};
    s1  = '0;
    if (rem != 8'd0) begin
      s1 = floor_pow2((rem < 8'd64) ? rem[6:0] : 7'd64);
    end
    if (s1 == 7'd0 && s0 > 7'd8) begin
      s0 = s0 >> 1;
      s1 = s0;
    end
    acc  = {4'd0, s0[6:3]};
    r[0] = acc;
    acc  = acc + {4'd0, s0[6:3]};
    r[1] = acc;
    acc  = acc + {4'd0, s1[6:3]};
    r[2] = acc;
    acc  = acc + {4'd0, s1[6:3]};
    r[3] = acc;
    r[4] = acc;
    return r;
  endfunction

  function automatic logic [1:0] smram_route(logic [7:0] s);
    logic [1:0] r;
    r = ROUTE_EXT;
    if (s[3]) begin
      if ((s & 8'h78) == 8'h48) begin
        r = ROUTE_INT;
      end else if ((s & 8'h28) == 8'h28) begin
        r = ROUTE_INT_RD;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/host_bridge_config_space.sv -----
`timescale 1ns / 1ps
// channel   | ports                                           | handshake
// ----------+-------------------------------------------------+--------------------------
// request   | op_i func_num_i reg_addr_i write_data_i         | start & !busy
// result    | read_data_o smram_route_o map_update_o          | result_valid_o, one cycle
//           | first_window_o first_state_o second_valid_o     |
//           | second_state_o                                  |
// config    | cfg_we_i cfg_wdata_i                            | cfg_we_i
//
// each transfer has two steps: the byte store read, then the merge and
// write-back; busy is high for the second of them.
// the result appears on the cycle after write-back, while the next transfer is taken.
// reset needs no clearing pass: per-byte valid bits select the reset values.
// the receiver cannot stall; results are never held.
module host_bridge_config_space (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       op_i,
  input  logic [2:0] func_num_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  output logic       result_valid_o,
  output logic [7:0] read_data_o,
  output logic [1:0] smram_route_o,
  output logic       map_update_o,
  output logic [3:0] first_window_o,
  output logic [1:0] first_state_o,
  output logic       second_valid_o,
  output logic [1:0] second_state_o
);

  logic              accept;
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [2:0]        s1_fn_q;
  logic [7:0]        s1_addr_q;
  logic [7:0]        s1_wdata_q;
  logic [7:0]        old_byte;
  hbcs_pkg::mem_wr_t mem_wr;
  hbcs_pkg::rows_t   rows;
  logic [7:0]        smram_q, smram_d;
  logic              lock_q, lock_d;
  logic [7:0]        rdata_d;
  logic              upd_d, sv_d;
  logic [3:0]        fw_d;
  logic [1:0]        fs_d, ss_d;
  logic [7:0]        pam_off;
  logic [7:0]        row_off;
  logic              fn0_wr;

  assign accept = start && !busy;
  assign busy   = s1_valid_q;

  hbcs_byte_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (reg_addr_i),
    .wr_i      (mem_wr),
    .rd_data_o (old_byte)
  );

  hbcs_rows u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rows_o      (rows)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_i;
      s1_fn_q    <= func_num_i;
      s1_addr_q  <= reg_addr_i;
      s1_wdata_q <= write_data_i;
    end
  end

  assign fn0_wr  = s1_valid_q && s1_op_q == hbcs_pkg::OP_WRITE &&
                   s1_fn_q == hbcs_pkg::FUNC_HOST;
  assign pam_off = s1_addr_q - hbcs_pkg::ADDR_PAM1;
  assign row_off = s1_addr_q - hbcs_pkg::ADDR_DRB0;

  // masked merge and write-back
  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.addr = s1_addr_q;
    mem_wr.data = 8'h00;
    smram_d     = smram_q;
    lock_d      = lock_q;
    if (fn0_wr) begin
      mem_wr.en = 1'b1;
      case (s1_addr_q)
        hbcs_pkg::ADDR_CMD:    mem_wr.data = (old_byte & 8'hFD) | (s1_wdata_q & 8'h02);
        hbcs_pkg::ADDR_STATUS: mem_wr.data = old_byte & ~(s1_wdata_q & 8'h30);
        hbcs_pkg::ADDR_LAT:    mem_wr.data = s1_wdata_q & 8'hF8;
        hbcs_pkg::ADDR_BIST:   mem_wr.data = s1_wdata_q & 8'h40;
        hbcs_pkg::ADDR_PCON:   mem_wr.data = s1_wdata_q & 8'hEF;
        hbcs_pkg::ADDR_CC:     mem_wr.data = (old_byte & 8'h04) | (s1_wdata_q & 8'hFB);
        hbcs_pkg::ADDR_DRAMC:  mem_wr.data = s1_wdata_q & 8'hCF;
        hbcs_pkg::ADDR_DRAMT:  mem_wr.data = s1_wdata_q & 8'h7F;
        hbcs_pkg::ADDR_PAM0:   mem_wr.data = s1_wdata_q & 8'h70;
        hbcs_pkg::ADDR_DRT:    mem_wr.data = s1_wdata_q & 8'h1F;
        hbcs_pkg::ADDR_SMRAM: begin
          mem_wr.en = 1'b0;
          if (lock_q) begin
            smram_d = (smram_q & 8'hDF) | (s1_wdata_q & 8'h20);
          end else begin
            smram_d = (smram_q & 8'h87) | (s1_wdata_q & 8'h78);
            lock_d  = s1_wdata_q[4];
            if (s1_wdata_q[4]) begin
              smram_d[6] = 1'b0;
            end
          end
        end
        default: begin
          mem_wr.en = 1'b0;
          if (s1_addr_q inside {[hbcs_pkg::ADDR_PAM1 : hbcs_pkg::ADDR_PAM6]}) begin
            mem_wr.en   = 1'b1;
            mem_wr.data = s1_wdata_q & 8'h77;
          end
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    rdata_d = 8'h00;
    upd_d   = 1'b0;
    fw_d    = 4'd0;
    fs_d    = 2'd0;
    sv_d    = 1'b0;
    ss_d    = 2'd0;
    if (s1_op_q == hbcs_pkg::OP_READ) begin
      if (s1_fn_q != hbcs_pkg::FUNC_HOST) begin
        rdata_d = hbcs_pkg::FUNC_ABSENT;
      end else if (s1_addr_q == hbcs_pkg::ADDR_SMRAM) begin
        rdata_d = smram_q;
      end else if (s1_addr_q inside {[hbcs_pkg::ADDR_DRB0 : hbcs_pkg::ADDR_DRB4]}) begin
        rdata_d = rows[row_off[2:0]];
      end else begin
        rdata_d = old_byte;
      end
    end else if (s1_fn_q == hbcs_pkg::FUNC_HOST) begin
      if (s1_addr_q == hbcs_pkg::ADDR_PAM0) begin
        upd_d = 1'b1;
        fw_d  = hbcs_pkg::PAM0_WINDOW;
        fs_d  = s1_wdata_q[5:4];
      end else if (s1_addr_q inside {[hbcs_pkg::ADDR_PAM1 : hbcs_pkg::ADDR_PAM6]}) begin
        upd_d = 1'b1;
        fw_d  = {pam_off[2:0], 1'b0};
        fs_d  = s1_wdata_q[1:0];
        sv_d  = 1'b1;
        ss_d  = s1_wdata_q[5:4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      result_valid_o <= 1'b0;
      smram_q        <= hbcs_pkg::SMRAM_RESET;
      lock_q         <= 1'b0;
    end else begin
      s1_valid_q     <= accept;
      result_valid_o <= s1_valid_q;
      smram_q        <= smram_d;
      lock_q         <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      read_data_o    <= rdata_d;
      smram_route_o  <= hbcs_pkg::smram_route(smram_d);
      map_update_o   <= upd_d;
      first_window_o <= fw_d;
      first_state_o  <= fs_d;
      second_valid_o <= sv_d;
      second_state_o <= ss_d;
    end
  end

endmodule

// ----- src/hbcs_byte_mem.sv -----
`timescale 1ns / 1ps
module hbcs_byte_mem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [7:0]       rd_addr_i,
  input  hbcs_pkg::mem_wr_t wr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0]   mem [256];
  logic [255:0] valid_q;
  logic [7:0]   rd_q;
  logic         rd_vld_q;
  logic [7:0]   rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // entries never written read as their reset value
  assign rd_data_o = rd_vld_q ? rd_q : hbcs_pkg::rst_byte(rd_addr_q);

endmodule

// ----- src/hbcs_rows.sv -----
`timescale 1ns / 1ps
module hbcs_rows (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_wdata_i,
  output hbcs_pkg::rows_t     rows_o
);

  hbcs_pkg::rows_t rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= hbcs_pkg::derive_rows(hbcs_pkg::RAM_RESET_MB);
    end else if (cfg_we_i) begin
      rows_q <= hbcs_pkg::derive_rows(cfg_wdata_i);
    end
  end

  assign rows_o = rows_q;

endmodule
